### hw/rtl/frustum_box_classifier_top_macros.svh
// ----------------------------------------------------------------------------
// frustum box classifier assertion macros
// concurrent checks on clk, with or without the reset as disable condition
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_CLASSIFIER_TOP_MACROS_SVH
`define FRUSTUM_BOX_CLASSIFIER_TOP_MACROS_SVH
`ifndef SYNTH
// check that is switched off while rst is high
`define FBC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fbc check failed");
// check that also runs during reset
`define FBC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fbc reset check failed");
`else
`define FBC_ASSERT(label, prop)
`define FBC_ASSERT_RST(label, prop)
`endif
`endif

### hw/rtl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg
// shared types and constants of the frustum box classifier
// ----------------------------------------------------------------------------
package fbc_pkg;

  // default parameter values
  localparam int PLANE_COUNT_DEF = 6;
  localparam int COORD_BITS_DEF  = 16;

  // register file and mask geometry
  localparam int REG_COUNT   = 6;
  localparam int MASK_BITS   = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int COEF_W      = 16;
  localparam int FRAC_BITS   = 14;
  localparam int HINT_W      = 4;

  // hint value meaning no plane
  localparam logic [HINT_W-1:0] HINT_NONE = 4'hF;

  // classification codes
  typedef enum logic [1:0] {
    VERDICT_INSIDE    = 2'd0,
    VERDICT_INTERSECT = 2'd1,
    VERDICT_OUTSIDE   = 2'd2
  } verdict_t;

endpackage

### hw/rtl/frustum_box_classifier_top.sv
// a result passes the stage a, b and c registers and then the result registers
// throughput: one box per cycle while busy is low; busy is registered and clears once reset is released
// the stages are products, plane sums, plane compare and mask/hint resolve
// reset clears all plane registers to zero and empties the pipeline
// busy stays high during reset until its register is clocked with reset low; done never stalls
// ----------------------------------------------------------------------------
// frustum_box_classifier_top
// classifies a box against the configured planes with plane masking and a
// last-outside hint, fully pipelined
// ----------------------------------------------------------------------------
`include "frustum_box_classifier_top_macros.svh"

module frustum_box_classifier_top #(
  parameter int PLANE_COUNT = fbc_pkg::PLANE_COUNT_DEF,
  parameter int COORD_BITS  = fbc_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_BITS-1:0]        box_min_x,
  input  logic signed [COORD_BITS-1:0]        box_min_y,
  input  logic signed [COORD_BITS-1:0]        box_min_z,
  input  logic signed [COORD_BITS-1:0]        box_max_x,
  input  logic signed [COORD_BITS-1:0]        box_max_y,
  input  logic signed [COORD_BITS-1:0]        box_max_z,
  input  logic [fbc_pkg::MASK_BITS-1:0]       inside_mask_in,
  input  logic signed [fbc_pkg::HINT_W-1:0]   hint_plane_in,
  // result channel
  output logic                                done,
  output logic [1:0]                          verdict,
  output logic [fbc_pkg::MASK_BITS-1:0]       inside_mask_out,
  output logic signed [fbc_pkg::HINT_W-1:0]   hint_plane_out,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fbc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fbc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int PROD_W = fbc_pkg::COEF_W + COORD_BITS;
  localparam int OFS_W  = fbc_pkg::COEF_W + fbc_pkg::FRAC_BITS;
  localparam int SUM_W  = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;
  localparam int MB     = fbc_pkg::MASK_BITS;
  localparam int VM_N   = (PLANE_COUNT < MB) ? PLANE_COUNT : MB;
  localparam logic [MB-1:0] VALID_MASK = MB'((1 << VM_N) - 1);

  typedef logic signed [PROD_W-1:0] prod3_t [3];
  typedef logic signed [COORD_BITS-1:0] coord3_t [3];

  // plane registers
  logic [fbc_pkg::CFG_DATA_W-1:0] plane [PLANE_COUNT];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    for (int i = 0; i < PLANE_COUNT; i++) begin
      if (rst) begin
        plane[i] <= '0;
      end else if (cfg_valid && cfg_ready && cfg_index == fbc_pkg::CFG_IDX_W'(i)
                   && i < fbc_pkg::REG_COUNT) begin
        plane[i] <= cfg_data;
      end
    end
  end

  // busy only around reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  logic accept;
  assign accept = start && !busy;

  // stage a: corner select and products
  coord3_t bmin, bmax;
  assign bmin[0] = box_min_x;
  assign bmin[1] = box_min_y;
  assign bmin[2] = box_min_z;
  assign bmax[0] = box_max_x;
  assign bmax[1] = box_max_y;
  assign bmax[2] = box_max_z;

  logic                a_vld;
  prod3_t              a_pfar  [PLANE_COUNT];
  prod3_t              a_pnear [PLANE_COUNT];
  logic [MB-1:0]       a_mask;
  logic                a_hint_ok;
  logic [2:0]          a_hint;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PLANE_COUNT; i++) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [fbc_pkg::COEF_W-1:0] n;
        logic                              pos;
        n   = plane[i][fbc_pkg::COEF_W*a +: fbc_pkg::COEF_W];
        pos = !n[fbc_pkg::COEF_W-1] && (n != '0);
        a_pfar[i][a]  <= PROD_W'(n) * PROD_W'(pos ? bmax[a] : bmin[a]);
        a_pnear[i][a] <= PROD_W'(n) * PROD_W'(pos ? bmin[a] : bmax[a]);
      end
    end
    a_mask    <= inside_mask_in;
    a_hint_ok <= !hint_plane_in[3] && ({1'b0, hint_plane_in[2:0]} < 4'(PLANE_COUNT));
    a_hint    <= hint_plane_in[2:0];
  end

  // stage b: distance sums
  logic                    b_vld;
  logic signed [SUM_W-1:0] b_dfar  [PLANE_COUNT];
  logic signed [SUM_W-1:0] b_dnear [PLANE_COUNT];
  logic [MB-1:0]           b_mask;
  logic                    b_hint_ok;
  logic [2:0]              b_hint;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PLANE_COUNT; i++) begin
      logic signed [fbc_pkg::COEF_W-1:0] w;
      logic signed [SUM_W-1:0]           wofs;
      w    = plane[i][fbc_pkg::COEF_W*3 +: fbc_pkg::COEF_W];
      wofs = SUM_W'(w) <<< fbc_pkg::FRAC_BITS;
      b_dfar[i]  <= SUM_W'(a_pfar[i][0]) + SUM_W'(a_pfar[i][1])
                  + SUM_W'(a_pfar[i][2]) + wofs;
      b_dnear[i] <= SUM_W'(a_pnear[i][0]) + SUM_W'(a_pnear[i][1])
                  + SUM_W'(a_pnear[i][2]) + wofs;
    end
    b_mask    <= a_mask;
    b_hint_ok <= a_hint_ok;
    b_hint    <= a_hint;
  end

  // stage c: per-plane classification
  logic                c_vld;
  fbc_pkg::verdict_t   c_res [PLANE_COUNT];
  logic [MB-1:0]       c_mask;
  logic                c_hint_ok;
  logic [2:0]          c_hint;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PLANE_COUNT; i++) begin
      if (b_dnear[i] > 0) begin
        c_res[i] <= fbc_pkg::VERDICT_OUTSIDE;
      end else if (b_dfar[i] > 0) begin
        c_res[i] <= fbc_pkg::VERDICT_INTERSECT;
      end else begin
        c_res[i] <= fbc_pkg::VERDICT_INSIDE;
      end
    end
    c_mask    <= b_mask;
    c_hint_ok <= b_hint_ok;
    c_hint    <= b_hint;
  end

  // stage d: hint first, then scan in index order
  fbc_pkg::verdict_t  verdict_next;
  logic [MB-1:0]      mask_next;
  logic [3:0]         hint_next;

  always_comb begin
    fbc_pkg::verdict_t hres;
    logic              htest;
    logic              stop;
    logic [7:0]        hsel;
    hres         = fbc_pkg::VERDICT_INSIDE;
    verdict_next = fbc_pkg::VERDICT_INSIDE;
    mask_next    = c_mask;
    hint_next    = fbc_pkg::HINT_NONE;
    stop         = 1'b0;
    // one-hot of the hinted plane, empty above the mask width
    hsel         = 8'd1 << c_hint;
    // hinted plane result
    for (int i = 0; i < PLANE_COUNT; i++) begin
      if (c_hint == 3'(i)) begin
        hres = c_res[i];
      end
    end
    htest = c_hint_ok && !(|(c_mask & hsel[MB-1:0]));
    if (htest) begin
      if (hres == fbc_pkg::VERDICT_OUTSIDE) begin
        stop         = 1'b1;
        verdict_next = fbc_pkg::VERDICT_OUTSIDE;
        hint_next    = {1'b0, c_hint};
      end else if (hres == fbc_pkg::VERDICT_INTERSECT) begin
        verdict_next = fbc_pkg::VERDICT_INTERSECT;
      end else begin
        mask_next = mask_next | hsel[MB-1:0];
      end
    end
    // remaining unmasked planes
    for (int i = 0; i < PLANE_COUNT; i++) begin
      if (!stop && !(i < MB && c_mask[i % MB]) && !(c_hint_ok && c_hint == 3'(i))) begin
        if (c_res[i] == fbc_pkg::VERDICT_OUTSIDE) begin
          stop         = 1'b1;
          verdict_next = fbc_pkg::VERDICT_OUTSIDE;
          hint_next    = 4'(i);
        end else if (c_res[i] == fbc_pkg::VERDICT_INTERSECT) begin
          verdict_next = fbc_pkg::VERDICT_INTERSECT;
        end else if (i < MB) begin
          mask_next[i % MB] = 1'b1;
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    verdict         <= verdict_next;
    inside_mask_out <= mask_next;
    hint_plane_out  <= hint_next;
  end

  // checks
  `FBC_ASSERT(a_latency, (start && !busy) |-> ##4 done)
  `FBC_ASSERT(a_hint_none, (done && verdict != fbc_pkg::VERDICT_OUTSIDE) |-> (hint_plane_out == fbc_pkg::HINT_NONE))
  `FBC_ASSERT(a_hint_range, (done && verdict == fbc_pkg::VERDICT_OUTSIDE) |-> !hint_plane_out[3])
  `FBC_ASSERT(a_inside_full, (done && verdict == fbc_pkg::VERDICT_INSIDE) |-> ((inside_mask_out & VALID_MASK) == VALID_MASK))
  `FBC_ASSERT_RST(a_reset_empty, rst |=> (busy && !done))

endmodule
